[hw/rtl/mp2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_pkg
// Types and constants shared by the 2x2 stride-2 max pooling stream.
// ----------------------------------------------------------------------------
package mp2_pkg;

	localparam int CHANNELS  = 3;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample_ch2;
		sample_t sample_ch1;
		sample_t sample_ch0;
	} pixel_t;

	typedef struct packed {
		logic    frame_last;
		sample_t max_ch2;
		sample_t max_ch1;
		sample_t max_ch0;
	} pool_t;

	// per-pixel decisions from the position counters
	typedef struct packed {
		logic left_load;
		logic line_rd;
		logic line_wr;
		logic emit;
		logic last;
	} ctrl_t;

endpackage

[hw/rtl/mp2_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_stream_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
interface mp2_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mp2_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mp2_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[hw/rtl/mp2_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_lane
// One channel: left pixel hold, pair maximum and window maximum.
// ----------------------------------------------------------------------------
module mp2_lane (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mp2_pkg::sample_t px,
	input  mp2_pkg::sample_t line_val,
	output mp2_pkg::sample_t pair_max,
	output mp2_pkg::sample_t win_max
);
	mp2_pkg::sample_t hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (load) begin
			hold_q <= px;
		end
	end

	assign pair_max = (hold_q >= px) ? hold_q : px;
	assign win_max  = (line_val >= pair_max) ? line_val : pair_max;
endmodule

[hw/rtl/mp2_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_ctrl
// Frame size registers and column/row counters deciding each pixel's role.
// ----------------------------------------------------------------------------
module mp2_ctrl #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512,
	localparam int CW = ($clog2(MAX_COLS) < 2) ? 2 : $clog2(MAX_COLS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mp2_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           advance,
	output mp2_pkg::ctrl_t                 ctl,
	output logic [CW-2:0]                  line_idx
);
	localparam int RW  = ($clog2(MAX_ROWS) < 1) ? 1 : $clog2(MAX_ROWS);
	localparam int CB  = $clog2(MAX_COLS + 1);
	localparam int RB  = $clog2(MAX_ROWS + 1);
	localparam int DW0 = (mp2_pkg::CFG_W > CB) ?
		((mp2_pkg::CFG_W > RB) ? mp2_pkg::CFG_W : RB) : ((CB > RB) ? CB : RB);
	localparam int DW  = DW0 + 1;

	logic [mp2_pkg::CFG_W-1:0] cols_q, rows_q;
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [DW-1:0]             cols_raw, rows_raw, cols_eff, rows_eff;
	logic [DW-1:0]             cols_even, rows_even, col_x, row_x;
	logic                      pool, end_line, end_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= mp2_pkg::CFG_W'(512);
			rows_q <= mp2_pkg::CFG_W'(512);
		end else if (cfg_we) begin
			case (cfg_index)
				mp2_pkg::REG_COLS: cols_q <= cfg_data;
				mp2_pkg::REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate to the supported frame size
	always_comb begin
		cols_raw = DW'(cols_q);
		rows_raw = DW'(rows_q);
		if (cols_raw < DW'(2))             cols_eff = DW'(2);
		else if (cols_raw > DW'(MAX_COLS)) cols_eff = DW'(MAX_COLS);
		else                               cols_eff = cols_raw;
		if (rows_raw < DW'(2))             rows_eff = DW'(2);
		else if (rows_raw > DW'(MAX_ROWS)) rows_eff = DW'(MAX_ROWS);
		else                               rows_eff = rows_raw;
		cols_even = {cols_eff[DW-1:1], 1'b0};
		rows_even = {rows_eff[DW-1:1], 1'b0};
	end

	assign col_x     = DW'(col_q);
	assign row_x     = DW'(row_q);
	assign pool      = (col_x < cols_even) && (row_x < rows_even);
	assign end_line  = (col_x + DW'(1)) >= cols_eff;
	assign end_frame = (row_x + DW'(1)) >= rows_eff;

	always_comb begin
		ctl.left_load = pool && !col_q[0];
		ctl.line_rd   = pool && !col_q[0] && row_q[0];
		ctl.line_wr   = pool && col_q[0] && !row_q[0];
		ctl.emit      = pool && col_q[0] && row_q[0];
		ctl.last      = (col_x == cols_even - DW'(1)) && (row_x == rows_even - DW'(1));
	end

	assign line_idx = col_q[CW-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_line) begin
				col_q <= '0;
				if (end_frame) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end
endmodule

[hw/rtl/max_pool_2x2_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_stream
// 2x2 stride-2 max pooling over a raster pixel stream, three signed channels.
//
// pixel: one word per pixel in raster order, three 16-bit samples.
// pooled: one word per 2x2 window, issued on the bottom-right pixel, with
//   frame_last set on the final window of the frame.
// cfg: cols_in_use (index 0) and rows_in_use (index 1); the user must write them only while
//   the block is idle, which the block itself does not enforce; values are saturated to
//   2..MAX_COLS / 2..MAX_ROWS. An odd trailing column or row is dropped.
// Throughput is one pixel per cycle unless a window-closing pixel waits on a stalled
//   receiver; each lane compares combinationally and the line store is read on
//   the left pixel of the pair, ahead of the right pixel. pooled.valid comes from
//   the output register, set at the edge that accepts the window's last pixel.
// When the receiver stalls, the output register holds its word and pixels
//   that do not close a window are still taken; a window-closing pixel waits.
// Reset clears counters and the left-pixel holds; the line store needs no
//   clearing since each entry is written on an even row before it is read.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mp2_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mp2_pkg::CFG_W-1:0]     cfg_data,
	mp2_stream_if.sink                    pixel,
	mp2_stream_if.source                  pooled
);
	localparam int CW  = ($clog2(MAX_COLS) < 2) ? 2 : $clog2(MAX_COLS);
	localparam int LD  = (MAX_COLS / 2 > 0) ? MAX_COLS / 2 : 1;
	localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
	localparam int LW  = mp2_pkg::CHANNELS * mp2_pkg::SAMPLE_W;

	mp2_pkg::ctrl_t   ctl;
	logic [CW-2:0]    line_idx;
	logic [LAW-1:0]   line_addr;
	logic             accept;
	logic [LW-1:0]    line_wdata, line_rdata;
	mp2_pkg::sample_t px       [mp2_pkg::CHANNELS];
	mp2_pkg::sample_t pair_max [mp2_pkg::CHANNELS];
	mp2_pkg::sample_t win_max  [mp2_pkg::CHANNELS];
	mp2_pkg::pool_t   pooled_q;
	logic             pooled_valid_q;

	assign pixel.ready = !pooled_valid_q || pooled.ready || !ctl.emit;
	assign accept      = pixel.valid && pixel.ready;

	mp2_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.ctl       (ctl),
		.line_idx  (line_idx)
	);

	assign line_addr = line_idx[LAW-1:0];

	assign px[0] = pixel.data.sample_ch0;
	assign px[1] = pixel.data.sample_ch1;
	assign px[2] = pixel.data.sample_ch2;

	for (genvar c = 0; c < mp2_pkg::CHANNELS; c++) begin : g_lane
		mp2_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept && ctl.left_load),
			.px       (px[c]),
			.line_val (line_rdata[c*mp2_pkg::SAMPLE_W +: mp2_pkg::SAMPLE_W]),
			.pair_max (pair_max[c]),
			.win_max  (win_max[c])
		);
		assign line_wdata[c*mp2_pkg::SAMPLE_W +: mp2_pkg::SAMPLE_W] = pair_max[c];
	end

	// pair maxima of the last even row
	mp2_ram #(
		.WIDTH (LW),
		.DEPTH (LD)
	) u_line (
		.clk     (clk),
		.wr_en   (accept && ctl.line_wr),
		.wr_addr (line_addr),
		.wr_data (line_wdata),
		.rd_en   (accept && ctl.line_rd),
		.rd_addr (line_addr),
		.rd_data (line_rdata)
	);

	// merge lanes into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pooled_valid_q <= 1'b0;
		end else if (accept && ctl.emit) begin
			pooled_valid_q <= 1'b1;
		end else if (pooled.ready) begin
			pooled_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ctl.emit) begin
			pooled_q.max_ch0    <= win_max[0];
			pooled_q.max_ch1    <= win_max[1];
			pooled_q.max_ch2    <= win_max[2];
			pooled_q.frame_last <= ctl.last;
		end
	end

	assign pooled.valid = pooled_valid_q;
	assign pooled.data  = pooled_q;
endmodule

[tb/sv/max_pool_2x2_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_stream_tb
// Self-checking bench for the 2x2 stride-2 max pooling stream. A scoreboard
// tracks the raster position, the left-pixel hold and the line of pair
// maxima, and predicts each pooled word from the accepted pixels. Directed
// frames cover the sample extremes, ties, saturated dimensions, odd trailing
// rows and columns, a long receiver stall and a full drain pause by the
// sender. Random frames of varied size follow, some of them cut short by a
// mid-frame shrink, with random idling on both sides.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream_tb;

	localparam int LINE_DEPTH    = 256;
	localparam int DIM_MAX       = 512;
	localparam int TOTAL_PIXELS  = 1150;
	localparam int QUIET_PIXELS  = 200;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LONG_HOLD     = 160;
	localparam int MAX_REPORTS   = 10;
	localparam int CYCLE_LIMIT   = 400000;

	class pool_scoreboard;
		int unsigned     cols_reg;
		int unsigned     rows_reg;
		int unsigned     col_pos;
		int unsigned     row_pos;
		mp2_pkg::pixel_t left_hold;
		mp2_pkg::pixel_t pair_line [LINE_DEPTH];
		mp2_pkg::pool_t  windows_due [$];
		int unsigned     mismatches;

		function new();
			cols_reg  = DIM_MAX;
			rows_reg  = DIM_MAX;
			col_pos   = 0;
			row_pos   = 0;
			left_hold = '0;
			foreach (pair_line[i])
				pair_line[i] = '0;
			mismatches = 0;
		endfunction

		static function int unsigned clamp_dim(int unsigned v);
			if (v < 2)
				return 2;
			if (v > DIM_MAX)
				return DIM_MAX;
			return v;
		endfunction

		static function mp2_pkg::sample_t smax(mp2_pkg::sample_t a, mp2_pkg::sample_t b);
			return (a >= b) ? a : b;
		endfunction

		function void write_reg(logic [mp2_pkg::CFG_IDX_W-1:0] idx,
				logic [mp2_pkg::CFG_W-1:0] val);
			if (idx == mp2_pkg::REG_COLS)
				cols_reg = 32'(val);
			else if (idx == mp2_pkg::REG_ROWS)
				rows_reg = 32'(val);
		endfunction

		function bit at_frame_start();
			return col_pos == 0 && row_pos == 0;
		endfunction

		function void note_pixel(mp2_pkg::pixel_t px);
			int unsigned     cols, rows, cols_even, rows_even, slot;
			mp2_pkg::pixel_t pair;
			mp2_pkg::pool_t  win;
			cols      = clamp_dim(cols_reg);
			rows      = clamp_dim(rows_reg);
			cols_even = cols & ~32'd1;
			rows_even = rows & ~32'd1;
			if (col_pos < cols_even && row_pos < rows_even) begin
				if (col_pos[0] == 1'b0) begin
					left_hold = px;
				end else begin
					slot = col_pos >> 1;
					pair.sample_ch0 = smax(left_hold.sample_ch0, px.sample_ch0);
					pair.sample_ch1 = smax(left_hold.sample_ch1, px.sample_ch1);
					pair.sample_ch2 = smax(left_hold.sample_ch2, px.sample_ch2);
					if (row_pos[0] == 1'b0) begin
						pair_line[slot] = pair;
					end else begin
						win.max_ch0 = smax(pair_line[slot].sample_ch0, pair.sample_ch0);
						win.max_ch1 = smax(pair_line[slot].sample_ch1, pair.sample_ch1);
						win.max_ch2 = smax(pair_line[slot].sample_ch2, pair.sample_ch2);
						win.frame_last = (col_pos == cols_even - 1) &&
							(row_pos == rows_even - 1);
						windows_due.push_back(win);
					end
				end
			end
			if (col_pos + 1 >= cols) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		function void check_pool(mp2_pkg::pool_t got);
			mp2_pkg::pool_t want;
			if (windows_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected pooled word: %0d %0d %0d last %0b",
						got.max_ch0, got.max_ch1, got.max_ch2, got.frame_last);
				return;
			end
			want = windows_due.pop_front();
			if (got.max_ch0 !== want.max_ch0 || got.max_ch1 !== want.max_ch1 ||
					got.max_ch2 !== want.max_ch2 || got.frame_last !== want.frame_last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("pooled mismatch: expected %0d %0d %0d last %0b",
						want.max_ch0, want.max_ch1, want.max_ch2, want.frame_last);
					$display("                 got      %0d %0d %0d last %0b",
						got.max_ch0, got.max_ch1, got.max_ch2, got.frame_last);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mp2_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mp2_pkg::CFG_W-1:0]     cfg_data;

	mp2_stream_if #(.T(mp2_pkg::pixel_t)) pix_if ();
	mp2_stream_if #(.T(mp2_pkg::pool_t))  pool_if ();

	max_pool_2x2_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pix_if),
		.pooled    (pool_if)
	);

	pool_scoreboard  sb = new();
	bit              quiet_tail = 1'b0;
	bit              src_gaps   = 1'b1;
	bit              hold_req   = 1'b0;
	int unsigned     pixels_sent = 0;
	int unsigned     cycle_count = 0;
	mp2_pkg::pixel_t prev_px = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int unsigned stall_left, hold_left;
		stall_left = 0;
		hold_left  = 0;
		pool_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pool_if.valid && pool_if.ready)
				sb.check_pool(pool_if.data);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0)
				hold_left--;
			else if (stall_left != 0)
				stall_left--;
			else if (!quiet_tail && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 11);
			pool_if.ready <= (hold_left == 0 && stall_left == 0);
		end
	end

	function automatic mp2_pkg::pixel_t mk_pixel(int a0, int a1, int a2);
		mp2_pkg::pixel_t px;
		px.sample_ch0 = mp2_pkg::sample_t'(a0);
		px.sample_ch1 = mp2_pkg::sample_t'(a1);
		px.sample_ch2 = mp2_pkg::sample_t'(a2);
		return px;
	endfunction

	function automatic mp2_pkg::sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return mp2_pkg::sample_t'(16'h8000);
			1: return mp2_pkg::sample_t'(16'h7fff);
			2: return '0;
			3: return '1;
			default: return mp2_pkg::sample_t'($urandom);
		endcase
	endfunction

	// occasional repeat of the last pixel gives ties
	function automatic mp2_pkg::pixel_t rand_pixel();
		if ($urandom_range(0, 15) != 0)
			prev_px = mk_pixel(rand_sample(), rand_sample(), rand_sample());
		return prev_px;
	endfunction

	task automatic send_pixel(input mp2_pkg::pixel_t px);
		pix_if.valid <= 1'b1;
		pix_if.data  <= px;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		sb.note_pixel(px);
		pixels_sent++;
		if (src_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_pixels(input int unsigned n);
		repeat (n) send_pixel(rand_pixel());
		pix_if.valid <= 1'b0;
	endtask

	task automatic finish_frame();
		while (!sb.at_frame_start())
			send_pixel(rand_pixel());
		pix_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.windows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_dims(input int unsigned cols, input int unsigned rows);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= mp2_pkg::REG_COLS;
		cfg_data  <= mp2_pkg::CFG_W'(cols);
		@(posedge clk);
		sb.write_reg(mp2_pkg::REG_COLS, mp2_pkg::CFG_W'(cols));
		cfg_index <= mp2_pkg::REG_ROWS;
		cfg_data  <= mp2_pkg::CFG_W'(rows);
		@(posedge clk);
		sb.write_reg(mp2_pkg::REG_ROWS, mp2_pkg::CFG_W'(rows));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned c, r, frame_px, frame_cnt;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pix_if.valid  = 1'b0;
		pix_if.data   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// most negative sample in every lane, most positive in lanes 0 and 1
		set_dims(2, 2);
		send_pixel(mk_pixel(32767, -32768, 0));
		send_pixel(mk_pixel(-32768, 32767, -1));
		send_pixel(mk_pixel(-1, -1, -32768));
		send_pixel(mk_pixel(0, -32768, -32768));
		pix_if.valid <= 1'b0;

		// dimensions below range, all four pixels tied
		set_dims(0, 1);
		repeat (4) send_pixel(mk_pixel(5, -7, -32768));
		pix_if.valid <= 1'b0;

		// odd trailing column and row, then a 4x2 frame
		set_dims(3, 3);
		send_pixels(9);
		set_dims(4, 2);
		send_pixels(8);

		// long receiver hold-off with the sender streaming
		set_dims(4, 4);
		src_gaps = 1'b0;
		hold_req = 1'b1;
		send_pixels(48);
		src_gaps = 1'b1;

		// sender pauses mid-frame until the pipe is empty
		send_pixels(10);
		while (sb.windows_due.size() != 0)
			@(posedge clk);
		send_pixels(6);

		// widest line, saturated from above, cut short in the second row
		set_dims(1023, 1023);
		send_pixels(520);
		set_dims(8, 2);
		finish_frame();

		// tallest frame cut short by a shrink
		set_dims(2, 512);
		send_pixels(30);
		set_dims(2, 4);
		finish_frame();

		while (pixels_sent < TOTAL_PIXELS) begin
			if (pixels_sent + QUIET_PIXELS >= TOTAL_PIXELS)
				quiet_tail = 1'b1;
			src_gaps = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 15))
				0: begin
					c = $urandom_range(13, 96);
					r = $urandom_range(0, 3);
				end
				1: begin
					c = $urandom_range(0, 3);
					r = $urandom_range(13, 64);
				end
				default: begin
					c = $urandom_range(0, 12);
					r = $urandom_range(0, 10);
				end
			endcase
			frame_px = pool_scoreboard::clamp_dim(c) * pool_scoreboard::clamp_dim(r);
			set_dims(c, r);
			if (c >= 4 && r >= 4 && $urandom_range(0, 4) == 0) begin
				// shrink only, so no line entry is read before it is written
				send_pixels($urandom_range(1, frame_px - 1));
				set_dims($urandom_range(0, c), $urandom_range(0, r));
				finish_frame();
			end else begin
				frame_cnt = $urandom_range(1, 3);
				if (pixels_sent + frame_cnt * frame_px > TOTAL_PIXELS)
					frame_cnt = 1;
				send_pixels(frame_cnt * frame_px);
			end
		end

		wait_drained();
		if (sb.windows_due.size() != 0)
			$display("%0d pooled words never arrived", sb.windows_due.size());
		if (sb.mismatches == 0 && sb.windows_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[max_pool_2x2_stream.f]
hw/rtl/mp2_pkg.sv
hw/rtl/mp2_stream_if.sv
hw/rtl/mp2_ram.sv
hw/rtl/mp2_lane.sv
hw/rtl/mp2_ctrl.sv
hw/rtl/max_pool_2x2_stream.sv
tb/sv/max_pool_2x2_stream_tb.sv
